/* rtl/ese_pkg.sv */
`timescale 1ns / 1ps

package ese_pkg;

   // Hardware counter width and the mask applied to the counter field
   localparam int COUNTER_BITS = 16;
   localparam int CNT_FIELD_W  = 16;
   localparam logic [CNT_FIELD_W-1:0] CNT_MASK =
      (COUNTER_BITS >= CNT_FIELD_W) ? {CNT_FIELD_W{1'b1}}
                                    : CNT_FIELD_W'((64'd1 << COUNTER_BITS) - 64'd1);

   // Configuration space
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_GAIN_IDX = 1'b0;
   localparam logic [31:0] GAIN_RESET = 32'd65536;

   // Smoothing weights, Q0.16
   localparam logic signed [16:0] OLD_WEIGHT = 17'sd34079;
   localparam logic signed [16:0] NEW_WEIGHT = 17'sd31457;

   // Datapath widths
   localparam int MUL_A_W = 33;
   localparam int MUL_B_W = 17;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int ACC_W   = 66;

   // Step counter
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_IDLE = 4'd0;
   localparam logic [STEP_W-1:0] STEP_RUN  = 4'd1;

   // Multiplier operand selects
   localparam logic [1:0] A_DIFF   = 2'd0;
   localparam logic [1:0] A_SMOOTH = 2'd1;
   localparam logic [1:0] A_INST   = 2'd2;

   localparam logic [1:0] B_GAIN_LO = 2'd0;
   localparam logic [1:0] B_GAIN_HI = 2'd1;
   localparam logic [1:0] B_OLD     = 2'd2;
   localparam logic [1:0] B_NEW     = 2'd3;

   // Accumulator operations
   localparam logic [2:0] ACC_HOLD     = 3'd0;
   localparam logic [2:0] ACC_LOAD     = 3'd1;
   localparam logic [2:0] ACC_ADD_SH16 = 3'd2;
   localparam logic [2:0] ACC_LOAD_RND = 3'd3;
   localparam logic [2:0] ACC_ADD      = 3'd4;

   typedef struct packed {
      logic [1:0] a_sel;
      logic [1:0] b_sel;
      logic       mul_en;
      logic [2:0] acc_op;
      logic       diff_ld;
      logic       sat_ld;
      logic       out_ld;
      logic       wait_out;
      logic       done;
   } ucode_word_type;

   localparam ucode_word_type UC_NOP = '{
      a_sel: A_DIFF, b_sel: B_GAIN_LO, mul_en: 1'b0, acc_op: ACC_HOLD,
      diff_ld: 1'b0, sat_ld: 1'b0, out_ld: 1'b0, wait_out: 1'b0, done: 1'b0};

   // Program for one sample tick
   function automatic ucode_word_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_word_type w;
      w = UC_NOP;
      case (step)
         4'd1: begin
            w.diff_ld = 1'b1;
         end
         4'd2: begin
            w.mul_en = 1'b1; w.a_sel = A_DIFF; w.b_sel = B_GAIN_LO;
         end
         4'd3: begin
            w.acc_op = ACC_LOAD;
            w.mul_en = 1'b1; w.a_sel = A_DIFF; w.b_sel = B_GAIN_HI;
         end
         4'd4: begin
            w.acc_op = ACC_ADD_SH16;
         end
         4'd5: begin
            w.sat_ld = 1'b1;
            w.mul_en = 1'b1; w.a_sel = A_SMOOTH; w.b_sel = B_OLD;
         end
         4'd6: begin
            w.acc_op = ACC_LOAD_RND;
            w.mul_en = 1'b1; w.a_sel = A_INST; w.b_sel = B_NEW;
         end
         4'd7: begin
            w.acc_op = ACC_ADD;
         end
         4'd8: begin
            w.out_ld = 1'b1; w.wait_out = 1'b1; w.done = 1'b1;
         end
         default: begin
            w = UC_NOP;
         end
      endcase
      return w;
   endfunction

endpackage

/* rtl/encoder_speed_estimator_top.sv */
`timescale 1ns / 1ps

// Wrap event: no response; the next request can be taken the cycle after.
// Sample tick: the response is registered at the end of the program and waits while
//   the previous response sits stalled; the next request is taken only once the
//   8-step microprogram running one shared 33x17 multiplier has finished.
// Synchronous active-high reset: gain back to 65536, wrap count, last position and
//   smoothed speed to zero, sequencer idle, no response pending.
module encoder_speed_estimator_top
   import ese_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_func,
   input  logic                  req_count_down,
   input  logic [15:0]           req_counter_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic signed [31:0]    rsp_position,
   output logic signed [31:0]    rsp_instant_speed,
   output logic signed [31:0]    rsp_filtered_speed,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(64'sd2147483647);
   localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(64'sd2147483648);
   localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(32768);

   logic [31:0]               gain_ff, gain_in;
   logic [15:0]               wrap_ff, wrap_in;
   logic [31:0]               last_ff, last_in;
   logic signed [31:0]        smooth_ff, smooth_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic [31:0]               pos_ff, pos_in;
   logic signed [31:0]        diff_ff, diff_in;
   logic signed [31:0]        inst_ff, inst_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [31:0]               rsp_pos_ff, rsp_pos_in;
   logic signed [31:0]        rsp_inst_ff, rsp_inst_in;
   logic signed [31:0]        rsp_filt_ff, rsp_filt_in;

   ucode_word_type            uc;
   logic                      req_take;
   logic                      tick_take;
   logic                      out_blocked;
   logic                      hold_step;
   logic                      gain_wr;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [ACC_W-1:0]   prod_ext;
   logic [31:0]               pos_calc;

   assign uc = ucode_rom(step_ff);

   // Handshakes
   assign req_stall   = (step_ff != STEP_IDLE);
   assign req_take    = req_valid && !req_stall;
   assign tick_take   = req_take && req_func;
   assign out_blocked = rsp_valid_ff && rsp_stall;
   assign hold_step   = uc.wait_out && out_blocked;

   // Configuration port
   assign csr_pready = 1'b1;
   assign gain_wr    = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[2] == REG_GAIN_IDX);
   assign csr_prdata = (csr_paddr[2] == REG_GAIN_IDX) ? gain_ff : '0;
   assign gain_in    = gain_wr ? csr_pwdata : gain_ff;

   // Wrap count steps up or down on a wrap event
   always_comb begin
      wrap_in = wrap_ff;
      if (req_take && !req_func) begin
         wrap_in = req_count_down ? wrap_ff - 16'd1 : wrap_ff + 16'd1;
      end
   end

   // Extended position: sign-extended wraps above the masked counter
   assign pos_calc = (32'(signed'(wrap_ff)) << COUNTER_BITS) +
                     32'(req_counter_value & CNT_MASK);
   assign pos_in   = tick_take ? pos_calc : pos_ff;

   // Sequencer: advance through the program, wait on a stalled response
   always_comb begin
      step_in = step_ff;
      if (step_ff == STEP_IDLE) begin
         if (tick_take) begin
            step_in = STEP_RUN;
         end
      end else if (!hold_step) begin
         step_in = uc.done ? STEP_IDLE : step_ff + 4'd1;
      end
   end

   // Position difference
   assign diff_in = uc.diff_ld ? signed'(pos_ff - last_ff) : diff_ff;
   assign last_in = uc.diff_ld ? pos_ff : last_ff;

   // Shared multiplier
   always_comb begin
      case (uc.a_sel)
         A_DIFF:   mul_a = MUL_A_W'(diff_ff);
         A_SMOOTH: mul_a = MUL_A_W'(smooth_ff);
         A_INST:   mul_a = MUL_A_W'(inst_ff);
         default:  mul_a = '0;
      endcase
      case (uc.b_sel)
         B_GAIN_LO: mul_b = signed'({1'b0, gain_ff[15:0]});
         B_GAIN_HI: mul_b = signed'({1'b0, gain_ff[31:16]});
         B_OLD:     mul_b = OLD_WEIGHT;
         B_NEW:     mul_b = NEW_WEIGHT;
         default:   mul_b = '0;
      endcase
   end
   assign prod_in  = uc.mul_en ? PROD_W'(mul_a) * PROD_W'(mul_b) : prod_ff;
   assign prod_ext = ACC_W'(prod_ff);

   // Accumulator
   always_comb begin
      case (uc.acc_op)
         ACC_HOLD:     acc_in = acc_ff;
         ACC_LOAD:     acc_in = prod_ext;
         ACC_ADD_SH16: acc_in = acc_ff + (prod_ext <<< 16);
         ACC_LOAD_RND: acc_in = prod_ext + RND_HALF;
         ACC_ADD:      acc_in = acc_ff + prod_ext;
         default:      acc_in = acc_ff;
      endcase
   end

   // Saturate the speed product to 32 bits
   always_comb begin
      inst_in = inst_ff;
      if (uc.sat_ld) begin
         if (acc_ff > SAT_MAX) begin
            inst_in = 32'sh7FFF_FFFF;
         end else if (acc_ff < SAT_MIN) begin
            inst_in = 32'sh8000_0000;
         end else begin
            inst_in = acc_ff[31:0];
         end
      end
   end

   // Commit the filter state and load the response register
   always_comb begin
      smooth_in    = smooth_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_pos_in   = rsp_pos_ff;
      rsp_inst_in  = rsp_inst_ff;
      rsp_filt_in  = rsp_filt_ff;
      if (uc.out_ld && !out_blocked) begin
         smooth_in    = acc_ff[47:16];
         rsp_valid_in = 1'b1;
         rsp_pos_in   = last_ff;
         rsp_inst_in  = inst_ff;
         rsp_filt_in  = acc_ff[47:16];
      end
   end

   // Control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff      <= GAIN_RESET;
         wrap_ff      <= '0;
         last_ff      <= '0;
         smooth_ff    <= '0;
         step_ff      <= STEP_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         gain_ff      <= gain_in;
         wrap_ff      <= wrap_in;
         last_ff      <= last_in;
         smooth_ff    <= smooth_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath and payload registers
   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      diff_ff     <= diff_in;
      inst_ff     <= inst_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_inst_ff <= rsp_inst_in;
      rsp_filt_ff <= rsp_filt_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_position       = signed'(rsp_pos_ff);
   assign rsp_instant_speed  = rsp_inst_ff;
   assign rsp_filtered_speed = rsp_filt_ff;

endmodule

/* rtl/ese_checker.sv */
`timescale 1ns / 1ps

module ese_checker
   import ese_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic                     req_func,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic signed [31:0]       rsp_position,
   input logic signed [31:0]       rsp_instant_speed,
   input logic signed [31:0]       rsp_filtered_speed
);

   // A stalled response stays valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // A stalled response keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_position) &&
                                 $stable(rsp_instant_speed) &&
                                 $stable(rsp_filtered_speed))
      else $error("response payload changed while stalled");

   // A sample tick occupies the sequencer
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_func |=> req_stall)
      else $error("request taken during sample tick processing");

   // A wrap event leaves the block free to take another request
   a_wrap_fast: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !req_func |=> !req_stall)
      else $error("wrap event left the block busy");

endmodule

bind encoder_speed_estimator_top ese_checker u_ese_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .req_func           (req_func),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_position       (rsp_position),
   .rsp_instant_speed  (rsp_instant_speed),
   .rsp_filtered_speed (rsp_filtered_speed)
);

/* tb/sv/speed_estimate_checker.sv */
`timescale 1ns / 1ps

module speed_estimate_checker
   import ese_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic                  req_func,
   input  logic                  req_count_down,
   input  logic [15:0]           req_counter_value,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic signed [31:0]    rsp_position,
   input  logic signed [31:0]    rsp_instant_speed,
   input  logic signed [31:0]    rsp_filtered_speed,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic                  csr_pready,
   output int                    mismatches,
   output int                    outstanding
);

   localparam logic FUNC_TICK = 1'b1;
   localparam logic [CSR_ADDR_W-1:0] GAIN_ADDR = CSR_ADDR_W'(4 * REG_GAIN_IDX);
   localparam logic [63:0] COUNTER_MASK = (64'd1 << COUNTER_BITS) - 64'd1;
   localparam longint OLD_WEIGHT_Q16 = 34079;
   localparam longint NEW_WEIGHT_Q16 = 31457;
   localparam longint ROUND_HALF     = 32768;
   localparam longint SPEED_MAX      = 64'sd2147483647;
   localparam longint SPEED_MIN      = -64'sd2147483648;
   localparam int     REPORT_LIMIT   = 50;

   typedef struct packed {
      logic signed [31:0] position;
      logic signed [31:0] instant;
      logic signed [31:0] filtered;
   } speed_sample_type;

   // Mirror of the estimator state
   logic [31:0]        gain_q16;
   logic [15:0]        wraps_seen;
   logic [31:0]        prev_position;
   logic signed [31:0] smooth_rpm;
   speed_sample_type   expected_speeds[$];
   int                 mismatch_total = 0;

   // Extend the position, scale the step to rpm and smooth it
   function automatic speed_sample_type predict_tick(input logic [15:0] counter);
      logic [63:0]        wraps_ext;
      logic [31:0]        pos;
      logic signed [31:0] diff;
      longint             product;
      longint             weighted;
      speed_sample_type   s;
      wraps_ext = {{48{wraps_seen[15]}}, wraps_seen};
      pos = 32'((wraps_ext << COUNTER_BITS) + (64'(counter) & COUNTER_MASK));
      diff = signed'(pos - prev_position);
      prev_position = pos;
      product = longint'(diff) * longint'({32'd0, gain_q16});
      if (product > SPEED_MAX) begin
         s.instant = 32'sh7fff_ffff;
      end else if (product < SPEED_MIN) begin
         s.instant = 32'sh8000_0000;
      end else begin
         s.instant = 32'(product);
      end
      weighted = OLD_WEIGHT_Q16 * longint'(smooth_rpm)
               + NEW_WEIGHT_Q16 * longint'(s.instant) + ROUND_HALF;
      smooth_rpm = 32'(weighted >>> 16);
      s.position = pos;
      s.filtered = smooth_rpm;
      return s;
   endfunction

   task automatic report_field(input string field, input logic signed [31:0] want_v,
                               input logic signed [31:0] got_v);
      if (want_v !== got_v) begin
         if (mismatch_total < REPORT_LIMIT) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
         end
         mismatch_total++;
      end
   endtask

   always @(posedge clock) begin : watch_channels
      speed_sample_type want;
      if (reset) begin
         gain_q16      = GAIN_RESET;
         wraps_seen    = '0;
         prev_position = '0;
         smooth_rpm    = '0;
         expected_speeds.delete();
      end else begin
         // Track gain writes to the gain address; the block also takes any address with bit 2 clear
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == GAIN_ADDR) begin
            gain_q16 = csr_pwdata;
         end

         // Compare each response against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (expected_speeds.size() == 0) begin
               if (mismatch_total < REPORT_LIMIT) begin
                  $display("%0t: unexpected response, expected none, got position %0d",
                           $time, rsp_position);
               end
               mismatch_total++;
            end else begin
               want = expected_speeds.pop_front();
               report_field("position", want.position, rsp_position);
               report_field("instant_speed", want.instant, rsp_instant_speed);
               report_field("filtered_speed", want.filtered, rsp_filtered_speed);
            end
         end

         // Advance the model on each accepted request
         if (req_valid && !req_stall) begin
            if (req_func == FUNC_TICK) begin
               expected_speeds.push_back(predict_tick(req_counter_value));
            end else if (req_count_down) begin
               wraps_seen = wraps_seen - 16'd1;
            end else begin
               wraps_seen = wraps_seen + 16'd1;
            end
         end
      end
      mismatches  <= mismatch_total;
      outstanding <= expected_speeds.size();
   end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench
   import ese_pkg::*;
();

   localparam logic FUNC_WRAP = 1'b0;
   localparam logic FUNC_TICK = 1'b1;
   localparam logic DIR_UP    = 1'b0;
   localparam logic DIR_DOWN  = 1'b1;
   localparam logic [CSR_ADDR_W-1:0] GAIN_ADDR  = CSR_ADDR_W'(4 * REG_GAIN_IDX);
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR = CSR_ADDR_W'(4);
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 12;
   localparam int WRAP_SPAN      = 4;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_func = 1'b0;
   logic                  req_count_down = 1'b0;
   logic [15:0]           req_counter_value = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic signed [31:0]    rsp_position;
   logic signed [31:0]    rsp_instant_speed;
   logic signed [31:0]    rsp_filtered_speed;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int          mismatches;
   int          outstanding;
   int          idle_cycles = 0;
   int          ticks_sent = 0;
   int          wraps_sent = 0;
   int          gain_settings = 0;
   logic        no_idle = 1'b0;
   logic [15:0] motion_counter = '0;

   encoder_speed_estimator_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_func           (req_func),
      .req_count_down     (req_count_down),
      .req_counter_value  (req_counter_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_position       (rsp_position),
      .rsp_instant_speed  (rsp_instant_speed),
      .rsp_filtered_speed (rsp_filtered_speed),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   speed_estimate_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_func           (req_func),
      .req_count_down     (req_count_down),
      .req_counter_value  (req_counter_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_position       (rsp_position),
      .rsp_instant_speed  (rsp_instant_speed),
      .rsp_filtered_speed (rsp_filtered_speed),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_pready         (csr_pready),
      .mismatches         (mismatches),
      .outstanding        (outstanding)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int draw_wait();
      if (no_idle) begin
         return 0;
      end
      return $urandom_range(0, 3);
   endfunction

   // Hold each request until the block takes it
   task automatic send_request(input logic func, input logic down, input logic [15:0] counter);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_func          <= func;
      req_count_down    <= down;
      req_counter_value <= counter;
      do @(posedge clock); while (req_stall);
      if (func == FUNC_TICK) begin
         ticks_sent++;
      end else begin
         wraps_sent++;
      end
   endtask

   task automatic send_tick(input logic [15:0] counter);
      send_request(FUNC_TICK, 1'($urandom), counter);
   endtask

   task automatic send_wrap(input logic down);
      send_request(FUNC_WRAP, down, 16'($urandom));
   endtask

   // Stop sending and wait out every pending response
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      if (addr == GAIN_ADDR) begin
         gain_settings++;
      end
   endtask

   // Mostly smooth motion with small counter steps, some wraps and some jumps
   task automatic send_motion(input int count);
      int roll;
      int delta;
      for (int i = 0; i < count; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < 20) begin
            send_wrap(1'($urandom));
         end else if (roll < 85) begin
            delta = int'($urandom_range(0, 4000)) - 2000;
            motion_counter = motion_counter + 16'(delta);
            send_tick(motion_counter);
         end else begin
            motion_counter = 16'($urandom);
            send_tick(motion_counter);
         end
      end
   endtask

   // Response side backpressure
   initial begin
      int hold;
      forever begin
         hold = draw_wait();
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Watchdog: end the run if no handshake happens for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_psel && csr_penable && csr_pwrite && csr_pready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Reset gain, first tick measured from position zero
      send_tick(16'h1234);
      send_tick(16'h1234);
      send_tick(16'hFFFF);
      send_tick(16'h0000);
      send_wrap(DIR_UP);
      send_tick(16'h0000);
      send_wrap(DIR_DOWN);
      send_wrap(DIR_DOWN);
      send_tick(16'hFFFF);

      // Largest gain: single count steps saturate both ways
      drain_results();
      write_csr(GAIN_ADDR, 32'hFFFF_FFFF);
      send_tick(16'hFFFF);
      send_tick(16'hFFFE);
      send_tick(16'hFFFF);

      // Zero gain lets the filter decay; a write to an unused address must not land
      drain_results();
      write_csr(GAIN_ADDR, 32'h0000_0000);
      send_tick(16'(~$urandom));
      send_tick(16'h8000);
      drain_results();
      write_csr(SPARE_ADDR, 32'hFFFF_FFFF);
      send_tick(16'h0001);

      // Unit gain, then walk the wrap count down through negative values and back up
      drain_results();
      write_csr(GAIN_ADDR, 32'd1);
      send_tick(16'h7FFF);
      send_tick(16'h00AA);
      no_idle = 1'b1;
      repeat (WRAP_SPAN) send_wrap(DIR_DOWN);
      send_tick(16'h00AA);
      repeat (2 * WRAP_SPAN) send_wrap(DIR_UP);
      send_tick(16'h00AA);
      send_wrap(DIR_DOWN);
      send_tick(16'h00AA);
      no_idle = 1'b0;

      // Random motion under several gains
      drain_results();
      write_csr(GAIN_ADDR, $urandom());
      send_motion(100);
      drain_results();
      write_csr(GAIN_ADDR, $urandom_range(1, 1 << 20));
      write_csr(SPARE_ADDR, $urandom());
      send_motion(100);
      drain_results();
      write_csr(GAIN_ADDR, 32'hFFFF_FFFF);
      send_motion(60);
      drain_results();
      write_csr(GAIN_ADDR, 32'h0000_0000);
      send_motion(40);
      drain_results();
      write_csr(GAIN_ADDR, $urandom_range(0, 1 << 18));
      no_idle = 1'b1;
      send_motion(100);
      no_idle = 1'b0;
      drain_results();

      $display("covered %0d sample ticks and %0d wrap events over %0d gain settings,",
               ticks_sent, wraps_sent, gain_settings);
      $display("including zero and full-scale gain, saturation and negative wrap counts");
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
